// ===== rtl/core/pgst_pkg.sv =====
package pgst_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_RES       = 16;
    localparam int RQ_CW         = $clog2(MAX_RES + 1);
    localparam int RQ_IW         = $clog2(MAX_RES);

    typedef enum logic [3:0] {
        OP_CREATE     = 4'd0,
        OP_REPRIO     = 4'd1,
        OP_NEWGROUP   = 4'd2,
        OP_STARTGROUP = 4'd3,
        OP_KILLGROUP  = 4'd4,
        OP_JOIN       = 4'd5,
        OP_RESUME     = 4'd6,
        OP_RESUMEALL  = 4'd7,
        OP_TERMINATE  = 4'd8,
        OP_CONTINUE   = 4'd9,
        OP_RUNREPORT  = 4'd10,
        OP_KILLALL    = 4'd11,
        OP_REAP       = 4'd12,
        OP_QUERY      = 4'd13
    } t_opcode;

    typedef enum logic [2:0] {
        ST_SUSP     = 3'd0,
        ST_FROZEN   = 3'd1,
        ST_RUNNABLE = 3'd2,
        ST_RUNNING  = 3'd3,
        ST_WAITING  = 3'd4,
        ST_ENDED    = 3'd5,
        ST_TERM     = 3'd6,
        ST_FAILED   = 3'd7
    } t_state;

    typedef enum logic [2:0] {
        EV_ACK       = 3'd0,
        EV_NEWTASK   = 3'd1,
        EV_NEWGROUP  = 3'd2,
        EV_GROUPDONE = 3'd3,
        EV_REMOVED   = 3'd4,
        EV_NOTFOUND  = 3'd5,
        EV_FULL      = 3'd6
    } t_event;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] task_id;
        logic [31:0] group_id;
        logic [7:0]  priority_req;
        logic [2:0]  reported_state;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [31:0] event_value;
        logic        running_found;
        logic [31:0] running_id;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [31:0] task_id;
        logic [7:0]  prio;
        t_state      state;
        logic [31:0] group_id;
    } t_slot;

    typedef struct packed {
        t_event      ev;
        logic [31:0] value;
    } t_ev;

    // Ids skip zero when they wrap.
    function automatic logic [31:0] next_id(logic [31:0] v);
        logic [31:0] n;
        n = v + 32'd1;
        if (n == 32'd0) begin
            n = 32'd1;
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/process_group_scheduler_table.sv =====
// Priority-ordered task table for a cooperative scheduler. The slots live in one
// RAM with a registered read, and a small sequencer walks it slot by slot (read,
// then update). A command takes up to two such passes (lookup, group start,
// regroup, reap or a stable move of one entry), always followed by a pass that
// finds the first running task, and then delivers its result words, one per
// cycle while the output does not stall. The last pass stops early at the first
// running task. The input stalls for the whole command, and result words all
// carry the running-task answer as it stands once the command is done. The table
// needs no clearing after reset: a fill count marks the used slots.
module process_group_scheduler_table #(
    parameter int NUM_SLOTS = pgst_pkg::NUM_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  pgst_pkg::t_in_word   i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output pgst_pkg::t_out_word  o_out
);
    import pgst_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int SW = $bits(t_slot);

    typedef enum logic [2:0] {
        S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_EX, S_ACT, S_MV_RD, S_MV_EX, S_OUT
    } t_fsm;

    typedef enum logic [3:0] {
        M_FIND, M_FINDRUN, M_START, M_KILLG, M_JOINREG, M_RESALL, M_KILLALL,
        M_REAP, M_RUNQ
    } t_mode;

    t_fsm              r_fsm;
    t_mode             r_mode;
    t_in_word          r_in;
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_w;
    logic [IW-1:0]     r_pos;
    t_slot             r_ent;
    logic [31:0]       r_sg;
    logic [31:0]       r_old;
    logic [31:0]       r_tid_last;
    logic [31:0]       r_gid_last;
    logic [RQ_CW-1:0]  r_rem;
    t_ev               r_rq [MAX_RES];
    logic [RQ_CW-1:0]  r_rcnt;
    logic [RQ_IW-1:0]  r_k;
    logic              r_found;
    logic [31:0]       r_rid;
    logic              r_back;
    logic              r_tryfwd;
    logic              r_fwdfirst;
    logic              r_started;

    logic [SW-1:0]     ram_rdata;
    t_slot             rd;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    t_slot             ram_wdata;
    logic [IW-1:0]     ram_raddr;

    t_opcode           op;
    logic              scan_end;
    logic              hit;
    logic              at_front;
    logic              at_end;
    logic              mv_cond;
    logic              mv_done;
    t_slot             act_ent;
    t_state            rep_state;
    logic              em;
    t_event            em_ev;
    logic [31:0]       em_val;
    logic              out_last;

    pgst_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd       = t_slot'(ram_rdata);
    assign op       = t_opcode'(r_in.opcode);
    assign scan_end = (r_i == r_used);
    assign at_front = (r_pos == '0);
    assign at_end   = (CW'(r_pos) == r_used - CW'(1));
    assign out_last = (RQ_CW'(r_k) == r_rcnt - RQ_CW'(1));

    always_comb begin
        if (r_back) begin
            mv_cond = r_ent.prio < rd.prio;
        end else if (r_fwdfirst) begin
            mv_cond = r_ent.prio > rd.prio;
        end else begin
            mv_cond = r_ent.prio >= rd.prio;
        end
    end

    always_comb begin
        unique case (r_mode) inside
            M_FIND:              hit = (rd.task_id == r_in.task_id);
            M_FINDRUN, M_RUNQ:   hit = (rd.state == ST_RUNNING);
            M_START:             hit = (rd.state == ST_RUNNABLE) && (rd.group_id == r_sg);
            M_KILLG:             hit = (rd.group_id == r_in.group_id);
            M_JOINREG:           hit = (rd.group_id == r_old);
            M_RESALL:            hit = (rd.state == ST_SUSP);
            M_KILLALL:           hit = (rd.state != ST_FROZEN);
            M_REAP:              hit = (rd.state >= ST_ENDED) && (r_rem < RQ_CW'(MAX_RES));
            default:             hit = 1'b0;
        endcase
    end

    // Per-command update of the slot that a lookup found.
    always_comb begin
        act_ent   = r_ent;
        rep_state = t_state'(r_in.reported_state);
        if (rep_state == ST_RUNNABLE || rep_state == ST_RUNNING) begin
            rep_state = ST_FAILED;
        end
        case (op) inside
            OP_JOIN: begin
                if (r_ent.state == ST_RUNNABLE || r_ent.state == ST_RUNNING ||
                    r_ent.state == ST_WAITING) begin
                    act_ent.state = ST_RUNNABLE;
                end
            end
            OP_RESUME: begin
                if (r_ent.state == ST_SUSP || r_ent.state == ST_RUNNABLE) begin
                    act_ent.state    = ST_RUNNABLE;
                    act_ent.group_id = r_in.group_id;
                end
            end
            OP_TERMINATE: act_ent.state = ST_TERM;
            OP_CONTINUE: begin
                if (r_ent.state == ST_WAITING) begin
                    act_ent.state = ST_RUNNING;
                end
            end
            OP_RUNREPORT: act_ent.state = rep_state;
            default: ;
        endcase
    end

    // RAM port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_ent;
        ram_raddr = r_i[IW-1:0];
        mv_done   = 1'b0;
        unique case (r_fsm)
            S_SCAN_EX: begin
                ram_waddr = r_i[IW-1:0];
                ram_wdata = rd;
                case (r_mode) inside
                    M_START: begin
                        ram_we          = hit;
                        ram_wdata.state = ST_RUNNING;
                    end
                    M_KILLG, M_KILLALL: begin
                        ram_we          = hit;
                        ram_wdata.state = ST_TERM;
                    end
                    M_JOINREG: begin
                        ram_we             = hit;
                        ram_wdata.group_id = r_in.group_id;
                    end
                    M_RESALL: begin
                        ram_we             = hit;
                        ram_wdata.state    = ST_RUNNABLE;
                        ram_wdata.group_id = r_in.group_id;
                    end
                    M_REAP: begin
                        ram_we    = !hit && (r_w != r_i);
                        ram_waddr = r_w[IW-1:0];
                    end
                    default: ;
                endcase
            end
            S_ACT: begin
                ram_we    = (op != OP_REPRIO);
                ram_wdata = act_ent;
            end
            S_MV_RD: begin
                ram_raddr = r_back ? r_pos - IW'(1) : r_pos + IW'(1);
                if ((r_back && at_front && !r_tryfwd) || (!r_back && at_end)) begin
                    ram_we  = 1'b1;
                    mv_done = 1'b1;
                end
            end
            S_MV_EX: begin
                if (mv_cond) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd;
                end else if (!(r_back && r_tryfwd)) begin
                    ram_we  = 1'b1;
                    mv_done = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result word generation; at most one per cycle.
    always_comb begin
        em     = 1'b0;
        em_ev  = EV_ACK;
        em_val = 32'd0;
        unique case (r_fsm) inside
            S_DISP: begin
                case (op) inside
                    OP_CREATE: begin
                        em = (r_used == CW'(NUM_SLOTS));
                        em_ev = EV_FULL;
                    end
                    OP_NEWGROUP: begin
                        em     = 1'b1;
                        em_ev  = EV_NEWGROUP;
                        em_val = next_id(r_gid_last);
                    end
                    OP_REPRIO, OP_STARTGROUP, OP_KILLGROUP, OP_JOIN, OP_RESUME,
                    OP_RESUMEALL, OP_TERMINATE, OP_CONTINUE, OP_RUNREPORT,
                    OP_KILLALL, OP_REAP: ;
                    default: em = 1'b1;
                endcase
            end
            S_SCAN_RD: begin
                if (scan_end) begin
                    case (r_mode)
                        M_FIND: begin
                            em     = 1'b1;
                            em_ev  = EV_NOTFOUND;
                            em_val = r_in.task_id;
                        end
                        M_FINDRUN: begin
                            em    = 1'b1;
                            em_ev = EV_NOTFOUND;
                        end
                        M_START: begin
                            if (op == OP_STARTGROUP) begin
                                em     = 1'b1;
                                em_ev  = r_started ? EV_ACK : EV_GROUPDONE;
                                em_val = r_sg;
                            end else begin
                                em     = !r_started;
                                em_ev  = EV_GROUPDONE;
                                em_val = r_sg;
                            end
                        end
                        M_JOINREG: begin
                            em     = 1'b1;
                            em_ev  = EV_GROUPDONE;
                            em_val = r_old;
                        end
                        M_RESALL: begin
                            em     = 1'b1;
                            em_val = r_in.group_id;
                        end
                        M_KILLALL: em = 1'b1;
                        M_REAP:    em = (r_rem == '0);
                        default: ;
                    endcase
                end
            end
            S_SCAN_EX: begin
                if (r_mode == M_REAP && hit) begin
                    em     = 1'b1;
                    em_ev  = EV_REMOVED;
                    em_val = rd.task_id;
                end
            end
            S_ACT: begin
                case (op) inside
                    OP_JOIN: begin
                        em     = (r_ent.state == ST_SUSP) || (r_ent.state == ST_FROZEN);
                        em_val = r_in.task_id;
                    end
                    OP_RESUME, OP_TERMINATE, OP_CONTINUE: begin
                        em     = 1'b1;
                        em_val = r_in.task_id;
                    end
                    OP_RUNREPORT: begin
                        em     = 1'b1;
                        em_val = r_ent.task_id;
                    end
                    default: ;
                endcase
            end
            S_MV_RD, S_MV_EX: begin
                em     = mv_done;
                em_ev  = (op == OP_CREATE) ? EV_NEWTASK : EV_ACK;
                em_val = (op == OP_CREATE) ? r_ent.task_id : r_in.task_id;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_IDLE;
            r_used     <= '0;
            r_tid_last <= 32'd0;
            r_gid_last <= 32'd0;
            r_rcnt     <= '0;
        end else begin
            if (em) begin
                r_rq[r_rcnt[RQ_IW-1:0]] <= '{ev: em_ev, value: em_val};
                r_rcnt                  <= r_rcnt + RQ_CW'(1);
            end
            unique case (r_fsm)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in      <= i_in;
                        r_rcnt    <= '0;
                        r_started <= 1'b0;
                        r_found   <= 1'b0;
                        r_rid     <= 32'd0;
                        r_fsm     <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_i   <= '0;
                    r_fsm <= S_SCAN_RD;
                    case (op) inside
                        OP_CREATE: begin
                            if (r_used == CW'(NUM_SLOTS)) begin
                                r_mode <= M_RUNQ;
                            end else begin
                                r_tid_last <= next_id(r_tid_last);
                                r_ent      <= '{task_id: next_id(r_tid_last),
                                                prio: r_in.priority_req,
                                                state: ST_SUSP, group_id: 32'd0};
                                r_pos      <= r_used[IW-1:0];
                                r_used     <= r_used + CW'(1);
                                r_back     <= 1'b1;
                                r_tryfwd   <= 1'b0;
                                r_fwdfirst <= 1'b1;
                                r_fsm      <= S_MV_RD;
                            end
                        end
                        OP_REPRIO, OP_JOIN, OP_RESUME, OP_TERMINATE, OP_CONTINUE:
                            r_mode <= M_FIND;
                        OP_NEWGROUP: begin
                            r_gid_last <= next_id(r_gid_last);
                            r_mode     <= M_RUNQ;
                        end
                        OP_STARTGROUP: begin
                            r_sg   <= r_in.group_id;
                            r_mode <= M_START;
                        end
                        OP_KILLGROUP: r_mode <= M_KILLG;
                        OP_RESUMEALL: r_mode <= M_RESALL;
                        OP_RUNREPORT: r_mode <= M_FINDRUN;
                        OP_KILLALL:   r_mode <= M_KILLALL;
                        OP_REAP: begin
                            r_w    <= '0;
                            r_rem  <= '0;
                            r_mode <= M_REAP;
                        end
                        default: r_mode <= M_RUNQ;
                    endcase
                end
                S_SCAN_RD: begin
                    if (scan_end) begin
                        r_i <= '0;
                        case (r_mode)
                            M_KILLG: begin
                                r_sg   <= r_in.group_id;
                                r_mode <= M_START;
                            end
                            M_REAP: begin
                                r_used <= r_w;
                                r_mode <= M_RUNQ;
                            end
                            M_RUNQ: begin
                                r_k   <= '0;
                                r_fsm <= S_OUT;
                            end
                            default: r_mode <= M_RUNQ;
                        endcase
                    end else begin
                        r_fsm <= S_SCAN_EX;
                    end
                end
                S_SCAN_EX: begin
                    r_i   <= r_i + CW'(1);
                    r_fsm <= S_SCAN_RD;
                    case (r_mode) inside
                        M_FIND, M_FINDRUN: begin
                            if (hit) begin
                                r_pos <= r_i[IW-1:0];
                                r_ent <= rd;
                                r_fsm <= S_ACT;
                            end
                        end
                        M_START: begin
                            // The first runnable member is started; the pass ends here.
                            if (hit) begin
                                r_started <= 1'b1;
                                r_i       <= r_used;
                            end
                        end
                        M_REAP: begin
                            if (hit) begin
                                r_rem <= r_rem + RQ_CW'(1);
                            end else begin
                                r_w <= r_w + CW'(1);
                            end
                        end
                        M_RUNQ: begin
                            if (hit) begin
                                r_found <= 1'b1;
                                r_rid   <= rd.task_id;
                                r_k     <= '0;
                                r_fsm   <= S_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
                S_ACT: begin
                    r_i    <= '0;
                    r_mode <= M_RUNQ;
                    r_fsm  <= S_SCAN_RD;
                    case (op)
                        OP_REPRIO: begin
                            r_ent.prio <= r_in.priority_req;
                            r_back     <= 1'b1;
                            r_tryfwd   <= 1'b1;
                            r_fwdfirst <= 1'b1;
                            r_fsm      <= S_MV_RD;
                        end
                        OP_JOIN: begin
                            if (r_ent.state != ST_SUSP && r_ent.state != ST_FROZEN) begin
                                r_old  <= r_ent.group_id;
                                r_mode <= M_JOINREG;
                            end
                        end
                        OP_TERMINATE: begin
                            if (r_ent.state == ST_RUNNING || r_ent.state == ST_WAITING) begin
                                r_sg   <= r_ent.group_id;
                                r_mode <= M_START;
                            end
                        end
                        OP_RUNREPORT: begin
                            if (rep_state != ST_WAITING) begin
                                r_sg   <= r_ent.group_id;
                                r_mode <= M_START;
                            end
                        end
                        default: ;
                    endcase
                end
                S_MV_RD: begin
                    if (mv_done) begin
                        r_i    <= '0;
                        r_mode <= M_RUNQ;
                        r_fsm  <= S_SCAN_RD;
                    end else if (r_back && at_front) begin
                        r_back <= 1'b0;
                    end else begin
                        r_fsm <= S_MV_EX;
                    end
                end
                S_MV_EX: begin
                    if (mv_cond) begin
                        // The neighbor slid into the hole; follow it.
                        r_pos      <= r_back ? r_pos - IW'(1) : r_pos + IW'(1);
                        r_tryfwd   <= r_tryfwd && !r_back;
                        r_fwdfirst <= r_fwdfirst && r_back;
                        r_fsm      <= S_MV_RD;
                    end else if (r_back && r_tryfwd) begin
                        r_back <= 1'b0;
                        r_fsm  <= S_MV_RD;
                    end else begin
                        r_i    <= '0;
                        r_mode <= M_RUNQ;
                        r_fsm  <= S_SCAN_RD;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (out_last) begin
                            r_fsm <= S_IDLE;
                        end else begin
                            r_k <= r_k + RQ_IW'(1);
                        end
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_fsm != S_IDLE);
    assign o_valid = (r_fsm == S_OUT);

    always_comb begin
        o_out.event_res     = r_rq[r_k].ev;
        o_out.event_value   = r_rq[r_k].value;
        o_out.running_found = r_found;
        o_out.running_id    = r_rid;
        o_out.last          = out_last;
    end

endmodule

// ===== rtl/core/pgst_ram.sv =====
module pgst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
